// ===== sv/maf_pkg.sv =====
// shared types and constants for the moving average filter
// no dependencies; imported by every module of the block
package maf_pkg;

	localparam int SAMPLE_W = 32;
	localparam int WIN_W    = 5;

	// word held in the input queue, as seen by the back end
	typedef struct packed {
		logic                       vld;
		logic signed [SAMPLE_W-1:0] sample;
	} fe_word_t;

	// serial divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== sv/maf_front.sv =====
// front end: two-entry input queue that takes sample words
// depends on maf_pkg
module maf_front import maf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       sample_stall,
	input  logic                       pop,
	output fe_word_t                   word
);

	logic signed [SAMPLE_W-1:0] entry_q [2];
	logic                       wr_ptr_q;
	logic                       rd_ptr_q;
	logic [1:0]                 count_q;
	logic                       push;

	assign sample_stall = (count_q == 2'd2);
	assign push         = sample_valid && !sample_stall;

	assign word.vld    = (count_q != 2'd0);
	assign word.sample = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= sample;
		end
	end

endmodule

// ===== sv/maf_div.sv =====
// serial signed divider: one quotient bit per cycle, truncates toward zero
// depends on maf_pkg
module maf_div import maf_pkg::*; #(
	parameter int NUM_W = 37
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [NUM_W-1:0]    dividend,
	input  logic [WIN_W-1:0]           divisor,
	output div_stat_t                  stat,
	output logic signed [SAMPLE_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [NUM_W-1:0] num_q;
	logic [WIN_W-1:0] rem_q;
	logic [WIN_W-1:0] div_q;

	logic [WIN_W:0]   rem_sh;
	logic [WIN_W:0]   rem_sub;
	logic             ge;
	logic [WIN_W-1:0] rem_nx;
	logic [NUM_W-1:0] dividend_abs;
	logic [NUM_W-1:0] quot_full;

	assign dividend_abs = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);

	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign ge      = (rem_sh >= {1'b0, div_q});
	assign rem_nx  = ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];

	assign quot_full = neg_q ? (~num_q + NUM_W'(1)) : num_q;
	assign quotient  = quot_full[SAMPLE_W-1:0];
	assign stat      = '{busy: busy_q, done: done_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NUM_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[NUM_W-1];
			num_q <= dividend_abs;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

endmodule

// ===== sv/maf_back.sv =====
// back end: sample ring, running sum, fill count and result register
// depends on maf_pkg and maf_div
module maf_back import maf_pkg::*; #(
	parameter int MAX_WINDOW = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       window_we,
	input  logic [WIN_W-1:0]           window_size,
	input  fe_word_t                   word,
	output logic                       pop,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [SAMPLE_W-1:0] average,
	output logic                       window_full
);

	localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SUM_W   = SAMPLE_W + $clog2(MAX_WINDOW) + 1;
	localparam int WIN_RST = (MAX_WINDOW > 31) ? 31 : MAX_WINDOW;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_UPD  = 3'b010,
		ST_DIV  = 3'b100
	} state_t;

	state_t                     state_q;
	logic [WIN_W-1:0]           win_q;
	logic [WIN_W-1:0]           fill_q;
	logic [IDX_W-1:0]           slot_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] old_q;
	logic                       full_pend_q;
	logic                       out_vld_q;
	logic signed [SAMPLE_W-1:0] average_q;
	logic                       full_q;

	logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW];

	logic                       cfg_ok;
	logic                       evict;
	logic signed [SUM_W-1:0]    sum_nx;
	logic [WIN_W-1:0]           fill_nx;
	logic [IDX_W:0]             slot_inc;
	logic [IDX_W-1:0]           slot_nx;
	logic                       div_start;
	div_stat_t                  div_stat;
	logic signed [SAMPLE_W-1:0] div_quot;
	logic                       out_free;
	logic                       out_load;

	assign cfg_ok = window_we && (window_size != '0)
		&& (32'(window_size) <= 32'(MAX_WINDOW));

	assign pop = (state_q == ST_IDLE) && word.vld;

	// oldest sample leaves the sum once the window is full
	assign evict   = (fill_q >= win_q);
	assign sum_nx  = sum_q - (evict ? SUM_W'(old_q) : SUM_W'(0)) + SUM_W'(sample_q);
	assign fill_nx = evict ? fill_q : fill_q + WIN_W'(1);

	assign slot_inc = {1'b0, slot_q} + (IDX_W+1)'(1);
	assign slot_nx  = (32'(slot_inc) >= 32'(win_q)) ? '0 : slot_inc[IDX_W-1:0];

	assign div_start = (state_q == ST_UPD);
	assign out_free  = !out_vld_q || !result_stall;
	assign out_load  = (state_q == ST_DIV) && div_stat.done && out_free;

	assign result_valid = out_vld_q;
	assign average      = average_q;
	assign window_full  = full_q;

	maf_div #(
		.NUM_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_nx),
		.divisor  (fill_nx),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= WIN_W'(WIN_RST);
			fill_q      <= '0;
			slot_q      <= '0;
			sum_q       <= '0;
			full_pend_q <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_ok) begin
				win_q  <= window_size;
				fill_q <= '0;
				slot_q <= '0;
				sum_q  <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					sum_q       <= sum_nx;
					fill_q      <= fill_nx;
					slot_q      <= slot_nx;
					full_pend_q <= (fill_nx >= win_q);
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// ring read is registered, issued on the cycle the word is popped
	always_ff @(posedge clk) begin
		if (pop) begin
			sample_q <= word.sample;
			old_q    <= ring[slot_q];
		end
		if (state_q == ST_UPD) begin
			ring[slot_q] <= sample_q;
		end
		if (out_load) begin
			average_q <= div_quot;
			full_q    <= full_pend_q;
		end
	end

endmodule

// ===== sv/moving_average_filter.sv =====
// moving average filter: the back end takes one word at a time and pops the next only
// after the bit-serial divider's quotient (over SUM_W = 33 + log2(MAX_WINDOW) bits)
// is loaded into the result register; a two-word input queue and the result register
// let either side stall alone. reset empties the history and sets the window to
// MAX_WINDOW, capped at 31
module moving_average_filter import maf_pkg::*; #(
	parameter int MAX_WINDOW = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       window_we,
	input  logic [WIN_W-1:0]           window_size,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [SAMPLE_W-1:0] average,
	output logic                       window_full
);

	fe_word_t word;
	logic     pop;

	maf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample       (sample),
		.sample_stall (sample_stall),
		.pop          (pop),
		.word         (word)
	);

	maf_back #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.window_we    (window_we),
		.window_size  (window_size),
		.word         (word),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.average      (average),
		.window_full  (window_full)
	);

endmodule

// ===== sv/maf_checker.sv =====
// port-level checks for the moving average filter, bound to the top level
// depends on maf_pkg
module maf_checker import maf_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       sample_valid,
	input logic                       sample_stall,
	input logic                       result_valid,
	input logic                       result_stall,
	input logic signed [SAMPLE_W-1:0] average,
	input logic                       window_full
);

	// words accepted but not yet delivered
	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = sample_valid && !sample_stall;
	assign out_acc = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			pend_q <= pend_q + {2'b00, in_acc} - {2'b00, out_acc};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(average) && $stable(window_full))
		else $error("stalled result changed");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 3'd0)
		else $error("result without an outstanding word");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 3'd4 |-> sample_stall)
		else $error("more words taken than the block can hold");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("outstanding word count overran");

endmodule

bind moving_average_filter maf_checker u_maf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.average      (average),
	.window_full  (window_full)
);

// ===== test/maf_result_check.sv =====
// result checker for the moving average filter: watches the sample, result and window ports,
// keeps its own running-mean state and compares every result word in order
// depends on maf_pkg
module maf_result_check import maf_pkg::*; #(
	parameter int MAX_WINDOW = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       window_we,
	input  logic [WIN_W-1:0]           window_size,
	input  logic                       sample_valid,
	input  logic                       sample_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       result_valid,
	input  logic                       result_stall,
	input  logic signed [SAMPLE_W-1:0] average,
	input  logic                       window_full,
	output int                         errors,
	output int                         pending
);

	localparam int TOTAL_W    = 36;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] average;
		logic                       window_full;
	} mean_t;

	mean_t means_due[$];

	logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW];
	logic signed [TOTAL_W-1:0]  total;
	int                         win_len;
	int                         slot;
	int                         held;
	int                         fail_cnt;

	function automatic void clear_history();
		slot  = 0;
		held  = 0;
		total = '0;
	endfunction

	// one sample in: drop the oldest once the window is full, then mean over what is held
	function automatic mean_t take_sample(input logic signed [SAMPLE_W-1:0] s);
		mean_t  m;
		longint q;
		if (held >= win_len) begin
			total -= ring[slot];
		end else begin
			held++;
		end
		ring[slot] = s;
		total += s;
		slot = (slot + 1 >= win_len) ? 0 : slot + 1;
		q = longint'(total) / held;
		m.average     = q[SAMPLE_W-1:0];
		m.window_full = (held >= win_len);
		return m;
	endfunction

	function automatic void note_failure();
		fail_cnt++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mean_t want;
		if (!arst_n) begin
			win_len = MAX_WINDOW;
			clear_history();
			means_due.delete();
			fail_cnt = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (means_due.size() == 0) begin
					note_failure();
					$display("%0t: unexpected result word, expected none, got average %0d full %0b",
						$time, average, window_full);
				end else begin
					want = means_due.pop_front();
					if (want.average !== average) begin
						note_failure();
						$display("%0t: average mismatch, expected %0d, got %0d",
							$time, want.average, average);
					end
					if (want.window_full !== window_full) begin
						note_failure();
						$display("%0t: window_full mismatch, expected %0b, got %0b",
							$time, want.window_full, window_full);
					end
				end
			end
			// out-of-range window sizes leave everything untouched
			if (window_we && window_size != 0 && window_size <= MAX_WINDOW) begin
				win_len = window_size;
				clear_history();
			end
			if (sample_valid && !sample_stall)
				means_due.push_back(take_sample(sample));
			errors  <= fail_cnt;
			pending <= means_due.size();
		end
	end

endmodule

// ===== test/tb_moving_average_filter.sv =====
// testbench top for the moving average filter: clock, reset, sample and window stimulus,
// result stall pattern and the final verdict
// depends on maf_pkg, moving_average_filter and maf_result_check
module tb_moving_average_filter import maf_pkg::*;;

	localparam int MAX_WINDOW   = 16;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int LIMIT        = 2_000_000;
	localparam int PHASES       = 5;
	localparam int SEGMENTS     = 4;
	localparam int SEG_WORDS    = 45;

	localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef enum int {MIXED, PINNED_HIGH, PINNED_LOW, NARROW} style_t;

	logic                       clk;
	logic                       arst_n;
	logic                       window_we;
	logic [WIN_W-1:0]           window_size;
	logic                       sample_valid;
	logic                       sample_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       result_valid;
	logic                       result_stall;
	logic signed [SAMPLE_W-1:0] average;
	logic                       window_full;

	int errors;
	int pending;
	int send_idle_pct;
	int stall_pct;
	int hold_reqs;

	moving_average_filter #(.MAX_WINDOW(MAX_WINDOW)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.window_we    (window_we),
		.window_size  (window_size),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.average      (average),
		.window_full  (window_full)
	);

	maf_result_check #(.MAX_WINDOW(MAX_WINDOW)) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.window_we    (window_we),
		.window_size  (window_size),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.average      (average),
		.window_full  (window_full),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// result side: random stall, or a long hold when the stimulus asks for one
	initial begin
		int holds_seen;
		holds_seen   = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_seen) begin
				holds_seen = hold_reqs;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
		end
	end

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		sample_valid <= 1'b1;
		sample       <= v;
		do @(posedge clk); while (sample_stall);
	endtask

	// every word gives a result, so an empty expectation queue means the block is idle
	task automatic wait_drained();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] w);
		wait_drained();
		window_we   <= 1'b1;
		window_size <= w;
		@(posedge clk);
		window_we   <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input style_t style);
		int r;
		r = $urandom_range(9);
		case (style)
			PINNED_HIGH: return (r < 7) ? S_MAX : S_MAX - $urandom_range(3);
			PINNED_LOW:  return (r < 7) ? S_MIN : S_MIN + $urandom_range(3);
			NARROW:      return $signed($urandom_range(200)) - 100;
			default: begin
				case (r)
					0:       return S_MAX;
					1:       return S_MIN;
					2:       return '0;
					3:       return -1;
					4, 5:    return $signed($urandom_range(15)) - 8;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	initial begin
		logic [WIN_W-1:0] w;
		arst_n        = 1'b0;
		window_we     = 1'b0;
		window_size   = '0;
		sample_valid  = 1'b0;
		sample        = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_reqs     = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window of 16 from reset, partial fill with the extremes
		send_sample(S_MAX);
		send_sample(S_MAX);
		send_sample(S_MIN);
		// smallest window: each result is the word itself
		write_window(1);
		send_sample(S_MIN);
		send_sample(-1);
		send_sample(S_MAX);
		// out-of-range sizes are ignored, the window stays at 1
		write_window(0);
		write_window(17);
		write_window(31);
		send_sample(-3);
		send_sample(5);
		// mean of -1 over two truncates to zero; rewriting the same size clears history
		write_window(3);
		send_sample(7);
		send_sample(-8);
		write_window(3);
		send_sample(5);
		// window of 2 wrapping around at the extremes
		write_window(2);
		send_sample(S_MIN);
		send_sample(S_MIN);
		send_sample(S_MAX);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
				1:       begin send_idle_pct = 62; stall_pct <= 0;  end
				2:       begin send_idle_pct = 0;  stall_pct <= 62; end
				3:       begin send_idle_pct = 15; stall_pct <= 15; end
				default: begin send_idle_pct = 0;  stall_pct <= 0;  end
			endcase
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				if ($urandom_range(2) == 0)
					write_window($urandom_range(1) ? '0 : WIN_W'($urandom_range(31, 17)));
				w = (seg == 0) ? WIN_W'(MAX_WINDOW) :
				    (seg == 1) ? WIN_W'(1) : WIN_W'($urandom_range(MAX_WINDOW, 1));
				write_window(w);
				// last phase: results held off for a long stretch while words keep coming
				if (ph == PHASES - 1)
					hold_reqs <= hold_reqs + 1;
				for (int i = 0; i < SEG_WORDS; i++)
					send_sample(pick_sample(style_t'((seg + ph) % 4)));
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/maf_pkg.sv
sv/maf_front.sv
sv/maf_div.sv
sv/maf_back.sv
sv/moving_average_filter.sv
sv/maf_checker.sv
test/maf_result_check.sv
test/tb_moving_average_filter.sv
